[rtl/dependency_order_resolver_assert.svh]
// ----------------------------------------------------------------------------
// Dependency order resolver assertion macros
// Concurrent assertion wrappers, clocked on clk_i and gated by rst_ni.
// ----------------------------------------------------------------------------
`ifndef DEPENDENCY_ORDER_RESOLVER_ASSERT_SVH
`define DEPENDENCY_ORDER_RESOLVER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Property holds at every clock edge outside reset
`define DOR_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("dependency order resolver: assertion failed");
// Antecedent in one cycle implies consequent in the next
`define DOR_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("dependency order resolver: assertion failed");
`else
`define DOR_ASSERT(name, prop)
`define DOR_ASSERT_NEXT(name, pre, post)
`endif

`endif

[rtl/dor_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dependency order resolver package
// Shared types, codes and default sizes.
// ----------------------------------------------------------------------------
package dor_pkg;

  // default sizes
  localparam int unsigned MAX_MODULES_DEF = 32;
  localparam int unsigned MAX_DEPS_DEF    = 8;
  localparam int unsigned ID_BITS_DEF     = 32;

  // result field widths
  localparam int unsigned SLOT_W = 5;

  // command codes
  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_ADD_DEP  = 2'd1,
    CMD_RESOLVE  = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_e;

  // status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TBL_FULL  = 3'd1,
    ST_DEP_FULL  = 3'd2,
    ST_NO_MODULE = 3'd3,
    ST_CYCLE     = 3'd4,
    ST_ORDER     = 3'd5
  } status_e;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_DEG_DEP,
    S_DEG_RD,
    S_DEG_CMP,
    S_SEED,
    S_POP,
    S_POPW,
    S_RID,
    S_SCAN_DEP,
    S_SCAN_CMP,
    S_EMIT,
    S_EM_RD,
    S_EM_ID,
    S_EM_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] module_id;
    logic [31:0] dependency_id;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [31:0]       order_module_id;
    logic              last;
  } res_t;

endpackage

[rtl/dor_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dependency order resolver table RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dor_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/dependency_order_resolver.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Dependency order resolver
// Module table with dependency lists; emits an init order by Kahn's method.
// ----------------------------------------------------------------------------
// Register and add-dependency commands may be issued back to back; each
// strobes its single result on res_valid_o in the next cycle.
// Resolve holds busy_o high while one sequencer walks the tables through
// RAMs with registered read data, one id compare per step. The degree pass
// compares each dependency entry against every registered id, and queue
// seeding follows it. The ordering pass scans all dependency entries for
// each dequeued module, and the order is emitted one entry at a time, each
// read from the order table and then from the id table. Results cannot be
// stalled: each is valid for exactly one cycle and the last result of a
// command carries last.
// ----------------------------------------------------------------------------
`include "dependency_order_resolver_assert.svh"

module dependency_order_resolver #(
  parameter int unsigned MAX_MODULES = dor_pkg::MAX_MODULES_DEF,
  parameter int unsigned MAX_DEPS    = dor_pkg::MAX_DEPS_DEF,
  parameter int unsigned ID_BITS     = dor_pkg::ID_BITS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  dor_pkg::req_t req_i,
  output logic          res_valid_o,
  output dor_pkg::res_t res_o
);

  import dor_pkg::*;

  localparam int unsigned SLW = (MAX_MODULES > 1) ? $clog2(MAX_MODULES) : 1;
  localparam int unsigned CW  = $clog2(MAX_MODULES + 1);
  localparam int unsigned DCW = $clog2(MAX_DEPS + 1);
  localparam int unsigned DEP_DEPTH = MAX_MODULES * MAX_DEPS;
  localparam int unsigned DAW = (DEP_DEPTH > 1) ? $clog2(DEP_DEPTH) : 1;
  localparam int unsigned XW  = DAW + DCW + 1;
  localparam int unsigned IDW = (ID_BITS < 32) ? ID_BITS : 32;

  // flat dependency address: slot * MAX_DEPS + entry
  function automatic logic [DAW-1:0] dep_addr(logic [SLW-1:0] s, logic [DCW-1:0] d);
    logic [XW-1:0] a;
    a = XW'(s) * XW'(MAX_DEPS) + XW'(d);
    return a[DAW-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] to_slot(logic [SLW-1:0] s);
    logic [31:0] w;
    w = 32'(s);
    return w[SLOT_W-1:0];
  endfunction

  state_e         state_q, state_d;
  logic [CW-1:0]  count_q, count_d;
  logic [DCW-1:0] dcnt_q [MAX_MODULES];
  logic [DCW-1:0] dcnt_d [MAX_MODULES];
  logic [7:0]     indeg_q [MAX_MODULES];
  logic [7:0]     indeg_d [MAX_MODULES];
  logic [CW-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [DCW-1:0] d_q, d_d;
  logic [7:0]     deg_q, deg_d;
  logic           hit_q, hit_d;
  logic [CW-1:0]  head_q, head_d, tail_q, tail_d, ord_q, ord_d;
  res_t           res_q, res_d;
  logic           res_valid_q, res_valid_d;

  // RAM ports
  logic           mid_we, mid_re, dep_we, dep_re, que_we, que_re, ord_we, ord_re;
  logic [SLW-1:0] mid_waddr, mid_raddr, que_waddr, que_raddr, ord_waddr, ord_raddr;
  logic [DAW-1:0] dep_waddr, dep_raddr;
  logic [IDW-1:0] mid_wdata, mid_rdata, dep_wdata, dep_rdata;
  logic [SLW-1:0] que_wdata, que_rdata, ord_wdata, ord_rdata;

  // shared decode
  logic           accept, load_cmd;
  logic [SLW-1:0] i_slot, last_slot, dc_addr;
  logic [DCW-1:0] dc_sel;
  logic           i_end, d_end, j_end, q_room;
  logic [7:0]     dec_deg;

  assign accept    = start_i && !busy_o;
  assign load_cmd  = accept && (req_i.command == CMD_REGISTER ||
                                req_i.command == CMD_ADD_DEP);
  assign i_slot    = i_q[SLW-1:0];
  assign last_slot = SLW'(count_q - CW'(1));
  assign dc_addr   = (state_q == S_IDLE) ? last_slot : i_slot;
  assign dc_sel    = dcnt_q[dc_addr];
  assign i_end     = (i_q == count_q);
  assign d_end     = (d_q == dc_sel);
  assign j_end     = (j_q == count_q);
  assign q_room    = (tail_q < CW'(MAX_MODULES));
  assign dec_deg   = indeg_q[i_slot] - 8'd1;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && req_i.command == CMD_RESOLVE) begin
          state_d = S_DEG_DEP;
        end
      end
      S_DEG_DEP: begin
        if (i_end) begin
          state_d = S_SEED;
        end else if (!d_end) begin
          state_d = S_DEG_RD;
        end
      end
      S_DEG_RD: begin
        state_d = j_end ? S_DEG_DEP : S_DEG_CMP;
      end
      S_DEG_CMP: begin
        state_d = S_DEG_RD;
      end
      S_SEED: begin
        if (i_end) begin
          state_d = S_POP;
        end
      end
      S_POP: begin
        state_d = (head_q == tail_q) ? S_EMIT : S_POPW;
      end
      S_POPW: begin
        state_d = S_RID;
      end
      S_RID: begin
        state_d = S_SCAN_DEP;
      end
      S_SCAN_DEP: begin
        if (i_end) begin
          state_d = S_POP;
        end else if (!d_end) begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        state_d = S_SCAN_DEP;
      end
      S_EMIT: begin
        state_d = (ord_q != count_q || count_q == '0) ? S_IDLE : S_EM_RD;
      end
      S_EM_RD: begin
        state_d = S_EM_ID;
      end
      S_EM_ID: begin
        state_d = S_EM_OUT;
      end
      S_EM_OUT: begin
        state_d = (k_q + CW'(1) == count_q) ? S_IDLE : S_EM_RD;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d     = count_q;
    dcnt_d      = dcnt_q;
    indeg_d     = indeg_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    d_d         = d_q;
    deg_d       = deg_q;
    hit_d       = hit_q;
    head_d      = head_q;
    tail_d      = tail_q;
    ord_d       = ord_q;
    res_d       = res_q;
    res_valid_d = 1'b0;
    mid_we      = 1'b0;
    mid_waddr   = count_q[SLW-1:0];
    mid_wdata   = req_i.module_id[IDW-1:0];
    mid_re      = 1'b0;
    mid_raddr   = j_q[SLW-1:0];
    dep_we      = 1'b0;
    dep_waddr   = dep_addr(last_slot, dc_sel);
    dep_wdata   = req_i.dependency_id[IDW-1:0];
    dep_re      = 1'b0;
    dep_raddr   = dep_addr(i_slot, d_q);
    que_we      = 1'b0;
    que_waddr   = tail_q[SLW-1:0];
    que_wdata   = i_slot;
    que_re      = 1'b0;
    que_raddr   = head_q[SLW-1:0];
    ord_we      = 1'b0;
    ord_waddr   = ord_q[SLW-1:0];
    ord_wdata   = que_rdata;
    ord_re      = 1'b0;
    ord_raddr   = k_q[SLW-1:0];

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (req_i.command)
            CMD_REGISTER: begin
              res_valid_d = 1'b1;
              res_d.order_module_id = 32'(req_i.module_id[IDW-1:0]);
              res_d.last = 1'b1;
              if (count_q >= CW'(MAX_MODULES)) begin
                res_d.status = ST_TBL_FULL;
                res_d.slot   = '0;
              end else begin
                res_d.status = ST_OK;
                res_d.slot   = to_slot(count_q[SLW-1:0]);
                mid_we       = 1'b1;
                dcnt_d[count_q[SLW-1:0]] = '0;
                count_d      = count_q + CW'(1);
              end
            end
            CMD_ADD_DEP: begin
              res_valid_d = 1'b1;
              res_d.order_module_id = 32'(req_i.dependency_id[IDW-1:0]);
              res_d.last = 1'b1;
              if (count_q == '0) begin
                res_d.status = ST_NO_MODULE;
                res_d.slot   = '0;
              end else if (dc_sel >= DCW'(MAX_DEPS)) begin
                res_d.status = ST_DEP_FULL;
                res_d.slot   = to_slot(last_slot);
              end else begin
                res_d.status = ST_OK;
                res_d.slot   = to_slot(last_slot);
                dep_we       = 1'b1;
                dcnt_d[last_slot] = dc_sel + DCW'(1);
              end
            end
            CMD_RESOLVE: begin
              i_d    = '0;
              d_d    = '0;
              deg_d  = '0;
              head_d = '0;
              tail_d = '0;
              ord_d  = '0;
            end
            default: begin
            end
          endcase
        end
      end
      // degree pass: count entries that match any registered id
      S_DEG_DEP: begin
        if (i_end) begin
          i_d = '0;
        end else if (d_end) begin
          indeg_d[i_slot] = deg_q;
          i_d   = i_q + CW'(1);
          d_d   = '0;
          deg_d = '0;
        end else begin
          dep_re = 1'b1;
          j_d    = '0;
          hit_d  = 1'b0;
        end
      end
      S_DEG_RD: begin
        if (j_end) begin
          if (hit_q) begin
            deg_d = deg_q + 8'd1;
          end
          d_d = d_q + DCW'(1);
        end else begin
          mid_re = 1'b1;
        end
      end
      S_DEG_CMP: begin
        if (mid_rdata == dep_rdata) begin
          hit_d = 1'b1;
        end
        j_d = j_q + CW'(1);
      end
      // seed queue with zero-degree slots
      S_SEED: begin
        if (!i_end) begin
          if (indeg_q[i_slot] == 8'd0 && q_room) begin
            que_we = 1'b1;
            tail_d = tail_q + CW'(1);
          end
          i_d = i_q + CW'(1);
        end
      end
      S_POP: begin
        if (head_q != tail_q) begin
          que_re = 1'b1;
          head_d = head_q + CW'(1);
        end else begin
          k_d = '0;
        end
      end
      S_POPW: begin
        if (ord_q < CW'(MAX_MODULES)) begin
          ord_we = 1'b1;
          ord_d  = ord_q + CW'(1);
        end
        mid_re    = 1'b1;
        mid_raddr = que_rdata;
      end
      S_RID: begin
        i_d = '0;
        d_d = '0;
      end
      // release dependents of the dequeued module
      S_SCAN_DEP: begin
        if (!i_end) begin
          if (d_end) begin
            i_d = i_q + CW'(1);
            d_d = '0;
          end else begin
            dep_re = 1'b1;
          end
        end
      end
      S_SCAN_CMP: begin
        if (dep_rdata == mid_rdata) begin
          indeg_d[i_slot] = dec_deg;
          if (dec_deg == 8'd0 && q_room) begin
            que_we = 1'b1;
            tail_d = tail_q + CW'(1);
          end
        end
        d_d = d_q + DCW'(1);
      end
      S_EMIT: begin
        if (ord_q != count_q) begin
          res_valid_d = 1'b1;
          res_d.status = ST_CYCLE;
          res_d.slot   = '0;
          res_d.order_module_id = '0;
          res_d.last   = 1'b1;
        end else if (count_q == '0) begin
          res_valid_d = 1'b1;
          res_d.status = ST_OK;
          res_d.slot   = '0;
          res_d.order_module_id = '0;
          res_d.last   = 1'b1;
        end
      end
      S_EM_RD: begin
        ord_re = 1'b1;
      end
      S_EM_ID: begin
        mid_re    = 1'b1;
        mid_raddr = ord_rdata;
      end
      S_EM_OUT: begin
        res_valid_d = 1'b1;
        res_d.status = ST_ORDER;
        res_d.slot   = to_slot(ord_rdata);
        res_d.order_module_id = 32'(mid_rdata);
        res_d.last   = (k_q + CW'(1) == count_q);
        k_d = k_q + CW'(1);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      d_q         <= '0;
      deg_q       <= '0;
      hit_q       <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      ord_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      d_q         <= d_d;
      deg_q       <= deg_d;
      hit_q       <= hit_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      ord_q       <= ord_d;
      res_valid_q <= res_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    dcnt_q  <= dcnt_d;
    indeg_q <= indeg_d;
    res_q   <= res_d;
  end

  // tables
  dor_ram #(.WIDTH(IDW), .DEPTH(MAX_MODULES), .AW(SLW)) u_mid_ram (
    .clk_i   (clk_i),
    .we_i    (mid_we),
    .waddr_i (mid_waddr),
    .wdata_i (mid_wdata),
    .re_i    (mid_re),
    .raddr_i (mid_raddr),
    .rdata_o (mid_rdata)
  );

  dor_ram #(.WIDTH(IDW), .DEPTH(DEP_DEPTH), .AW(DAW)) u_dep_ram (
    .clk_i   (clk_i),
    .we_i    (dep_we),
    .waddr_i (dep_waddr),
    .wdata_i (dep_wdata),
    .re_i    (dep_re),
    .raddr_i (dep_raddr),
    .rdata_o (dep_rdata)
  );

  dor_ram #(.WIDTH(SLW), .DEPTH(MAX_MODULES), .AW(SLW)) u_que_ram (
    .clk_i   (clk_i),
    .we_i    (que_we),
    .waddr_i (que_waddr),
    .wdata_i (que_wdata),
    .re_i    (que_re),
    .raddr_i (que_raddr),
    .rdata_o (que_rdata)
  );

  dor_ram #(.WIDTH(SLW), .DEPTH(MAX_MODULES), .AW(SLW)) u_ord_ram (
    .clk_i   (clk_i),
    .we_i    (ord_we),
    .waddr_i (ord_waddr),
    .wdata_i (ord_wdata),
    .re_i    (ord_re),
    .raddr_i (ord_raddr),
    .rdata_o (ord_rdata)
  );

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // checks
  `DOR_ASSERT(a_count_bound, count_q <= CW'(MAX_MODULES))
  `DOR_ASSERT(a_queue_order, head_q <= tail_q)
  `DOR_ASSERT(a_more_results, (res_valid_o && !res_o.last) |-> busy_o)
  `DOR_ASSERT_NEXT(a_load_result, load_cmd, res_valid_o && res_o.last)

endmodule
